@@ design/vsrc_pkg.sv @@
// Shared constants and types of the variable-step RC low-pass filter.
`default_nettype none

package vsrc_pkg;

    localparam int FRAC_BITS    = 8;
    localparam int SAMPLE_WIDTH = 16;

    localparam int STATE_W     = SAMPLE_WIDTH + FRAC_BITS;
    localparam int MS_W        = 10;
    localparam int SEC_W       = 16;
    localparam int TIME_W      = 26;
    localparam int RC_W        = 24;
    localparam int MS_PER_SEC  = 1000;
    localparam logic [RC_W-1:0] RC_RESET = RC_W'(408);

    // The fixed-point dt saturates at 2**DTF_W - 1.
    localparam int DTF_W  = 61 - STATE_W;
    localparam int DT_LIM = DTF_W - FRAC_BITS;
    localparam int DEN_W  = ((DTF_W > RC_W) ? DTF_W : RC_W) + 1;

    localparam int ACC_W    = 64;
    localparam int Q_W      = STATE_W;
    localparam int MAX_STEP = (RC_W > Q_W) ? RC_W : Q_W;
    localparam int CNT_W    = $clog2(MAX_STEP);

    typedef struct packed {
        logic                      start;
        logic signed [ACC_W-1:0]   addend;
        logic signed [STATE_W-1:0] mcand;
        logic [RC_W-1:0]           mplier;
        logic [DEN_W-1:0]          den;
    } unit_req_t;

    typedef struct packed {
        logic                      done;
        logic signed [STATE_W-1:0] quot;
    } unit_rsp_t;

endpackage

`default_nettype wire

@@ design/vsrc_if.sv @@
// Handshake interfaces for the sample, result and configuration channels.
`default_nettype none

interface vsrc_in_if;
    import vsrc_pkg::*;

    logic                           valid;
    logic                           ready;
    logic [MS_W-1:0]                time_ms;
    logic [SEC_W-1:0]               time_sec;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, time_ms, time_sec, sample, input ready);
    modport sink   (input valid, time_ms, time_sec, sample, output ready);
endinterface

interface vsrc_out_if;
    import vsrc_pkg::*;

    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] filtered;

    modport source (output valid, filtered, input ready);
    modport sink   (input valid, filtered, output ready);
endinterface

interface vsrc_cfg_if;
    import vsrc_pkg::*;

    logic            valid;
    logic            ready;
    logic [RC_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

@@ design/vsrc_unit.sv @@
// Shared add/subtract unit that runs the shift-add multiply and the restoring divide.
`default_nettype none

module vsrc_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  vsrc_pkg::unit_req_t req,
    output vsrc_pkg::unit_rsp_t rsp
);
    import vsrc_pkg::*;

    typedef enum logic [4:0] {
        U_IDLE = 5'b00001,
        U_MUL  = 5'b00010,
        U_ABS  = 5'b00100,
        U_DIV  = 5'b01000,
        U_SIGN = 5'b10000
    } ustate_t;

    ustate_t                   state_reg, state_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [ACC_W-1:0]   mc_reg, mc_next;
    logic [RC_W-1:0]           mp_reg, mp_next;
    logic [DEN_W-1:0]          den_reg, den_next;
    logic                      neg_reg, neg_next;
    logic signed [STATE_W-1:0] q_reg, q_next;
    logic                      done_reg, done_next;

    logic [ACC_W-1:0] add_a;
    logic [ACC_W-1:0] add_b;
    logic             add_sub;
    logic [ACC_W-1:0] sum;
    logic [DEN_W:0]   div_trial;
    logic             qbit;

    assign div_trial = acc_reg[Q_W+DEN_W-1:Q_W-1];

    always_comb
    begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        unique case (state_reg)
            U_IDLE:
            begin
                add_a = '0;
            end
            U_MUL:
            begin
                add_a = acc_reg;
                add_b = mp_reg[0] ? mc_reg : '0;
            end
            U_ABS:
            begin
                add_b   = acc_reg;
                add_sub = acc_reg[ACC_W-1];
            end
            U_DIV:
            begin
                add_a   = ACC_W'(div_trial);
                add_b   = ACC_W'(den_reg);
                add_sub = 1'b1;
            end
            U_SIGN:
            begin
                add_b   = ACC_W'(acc_reg[Q_W-1:0]);
                add_sub = neg_reg;
            end
            default:
            begin
                add_a = '0;
            end
        endcase
    end

    assign sum  = add_a + (add_sub ? ~add_b : add_b) + ACC_W'(add_sub);
    assign qbit = ~sum[ACC_W-1];

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        mc_next    = mc_reg;
        mp_next    = mp_reg;
        den_next   = den_reg;
        neg_next   = neg_reg;
        q_next     = q_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            U_IDLE:
            begin
                if (req.start)
                begin
                    acc_next   = req.addend;
                    mc_next    = ACC_W'(req.mcand);
                    mp_next    = req.mplier;
                    den_next   = req.den;
                    cnt_next   = '0;
                    state_next = U_MUL;
                end
            end
            U_MUL:
            begin
                acc_next = sum;
                mc_next  = mc_reg <<< 1;
                mp_next  = mp_reg >> 1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(RC_W - 1))
                begin
                    state_next = U_ABS;
                end
            end
            U_ABS:
            begin
                neg_next   = acc_reg[ACC_W-1];
                acc_next   = sum;
                cnt_next   = '0;
                state_next = U_DIV;
            end
            U_DIV:
            begin
                acc_next[Q_W+DEN_W-1:Q_W] = qbit ? sum[DEN_W-1:0]
                                                 : acc_reg[Q_W+DEN_W-2:Q_W-1];
                acc_next[Q_W-1:0] = {acc_reg[Q_W-2:0], qbit};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(Q_W - 1))
                begin
                    state_next = U_SIGN;
                end
            end
            U_SIGN:
            begin
                q_next     = sum[STATE_W-1:0];
                done_next  = 1'b1;
                state_next = U_IDLE;
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
        q_reg   <= q_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;

endmodule

`default_nettype wire

@@ design/variable_step_rc_low_pass.sv @@
// Top level of the variable-step RC low-pass filter.
// Each sample transfer carries a seconds/milliseconds timestamp and a signed sample; the
// block takes dt in ms against the previous timestamp (zero if time runs backward) and
// returns y = (rc_time*y_prev + dt*x)/(rc_time + dt), truncated toward zero, with 8
// fraction bits, delivering the integer part of y. rc_time is in 1/256 ms and resets to
// 408. The shared adder walks one rc_time bit per cycle for the multiply and one quotient
// bit per cycle for the divide. The sample channel is ready only between samples; a
// finished result waits in an output register while the next sample is taken.
`default_nettype none

module variable_step_rc_low_pass (
    input  logic        clk,
    input  logic        rst_n,
    vsrc_cfg_if.sink    cfg,
    vsrc_in_if.sink     samples,
    vsrc_out_if.source  results
);
    import vsrc_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_TIME = 6'b000010,
        S_DT   = 6'b000100,
        S_PROD = 6'b001000,
        S_RUN  = 6'b010000,
        S_LOAD = 6'b100000
    } state_t;

    state_t                         state_reg, state_next;
    logic [MS_W-1:0]                ms_reg, ms_next;
    logic [SEC_W-1:0]               sec_reg, sec_next;
    logic signed [SAMPLE_WIDTH-1:0] x_reg, x_next;
    logic [TIME_W-1:0]              now_reg, now_next;
    logic [TIME_W-1:0]              dt_reg, dt_next;
    logic [TIME_W-1:0]              prev_time_reg, prev_time_next;
    logic signed [STATE_W-1:0]      prev_out_reg, prev_out_next;
    logic [RC_W-1:0]                rc_reg, rc_next;
    logic                           out_valid_reg, out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] out_data_reg, out_data_next;

    logic                             capped;
    logic [DTF_W-1:0]                 dtf;
    logic [DEN_W-1:0]                 den;
    logic signed [TIME_W+SAMPLE_WIDTH:0] dtx;
    logic signed [ACC_W-1:0]          xe;
    logic signed [ACC_W-1:0]          term2;
    logic                             out_free;

    unit_req_t req;
    unit_rsp_t rsp;

    assign capped = (dt_reg >> DT_LIM) != '0;
    assign dtf    = capped ? '1 : (DTF_W'(dt_reg) << FRAC_BITS);
    assign den    = DEN_W'(rc_reg) + DEN_W'(dtf);
    assign dtx    = $signed({1'b0, dt_reg}) * x_reg;
    assign xe     = ACC_W'(x_reg);
    assign term2  = capped ? (((xe <<< DTF_W) - xe) <<< FRAC_BITS)
                           : (ACC_W'(dtx) <<< (2 * FRAC_BITS));

    assign req.start  = (state_reg == S_PROD) && (den != '0);
    assign req.addend = term2;
    assign req.mcand  = prev_out_reg;
    assign req.mplier = rc_reg;
    assign req.den    = den;

    vsrc_unit u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    assign out_free = !out_valid_reg || results.ready;

    always_comb
    begin
        state_next     = state_reg;
        ms_next        = ms_reg;
        sec_next       = sec_reg;
        x_next         = x_reg;
        now_next       = now_reg;
        dt_next        = dt_reg;
        prev_time_next = prev_time_reg;
        prev_out_next  = prev_out_reg;
        rc_next        = rc_reg;
        out_valid_next = out_valid_reg && !results.ready;
        out_data_next  = out_data_reg;

        if (cfg.valid)
        begin
            rc_next = cfg.data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (samples.valid)
                begin
                    ms_next    = samples.time_ms;
                    sec_next   = samples.time_sec;
                    x_next     = samples.sample;
                    state_next = S_TIME;
                end
            end
            S_TIME:
            begin
                now_next   = TIME_W'(TIME_W'(sec_reg) * TIME_W'(MS_PER_SEC)
                                     + TIME_W'(ms_reg));
                state_next = S_DT;
            end
            S_DT:
            begin
                dt_next        = (now_reg >= prev_time_reg) ? (now_reg - prev_time_reg) : '0;
                prev_time_next = now_reg;
                state_next     = S_PROD;
            end
            S_PROD:
            begin
                // With a zero denominator the state is kept as it is.
                state_next = (den != '0) ? S_RUN : S_LOAD;
            end
            S_RUN:
            begin
                if (rsp.done)
                begin
                    prev_out_next = rsp.quot;
                    state_next    = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = prev_out_reg[STATE_W-1:FRAC_BITS];
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            prev_time_reg <= '0;
            prev_out_reg  <= '0;
            rc_reg        <= RC_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_time_reg <= prev_time_next;
            prev_out_reg  <= prev_out_next;
            rc_reg        <= rc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ms_reg       <= ms_next;
        sec_reg      <= sec_next;
        x_reg        <= x_next;
        now_reg      <= now_next;
        dt_reg       <= dt_next;
        out_data_reg <= out_data_next;
    end

    assign cfg.ready        = 1'b1;
    assign samples.ready    = (state_reg == S_IDLE);
    assign results.valid    = out_valid_reg;
    assign results.filtered = out_data_reg;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (samples.valid && samples.ready) |=> (state_reg == S_TIME))
        else $error("A sample transfer did not start the timestamp step.");

    a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> (state_reg == S_RUN))
        else $error("The arithmetic unit finished while the sequencer was not waiting.");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN && rsp.done) |=> (state_reg == S_LOAD
                                               && prev_out_reg == $past(rsp.quot)))
        else $error("The quotient was not taken into the filter state.");

    a_rose_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_LOAD))
        else $error("A result appeared outside the load step.");
`endif

endmodule

`default_nettype wire
